/* rtl/core/msscan_pkg.sv */
// Shared constants for the masked signature scanner: field widths, codes and opcode bytes.
package msscan_pkg;

	// Default sizes
	localparam int MAX_PATTERN_DEF = 8;
	localparam int LOOKBACK_DEF    = 19;

	// Field and register widths
	localparam int CODE_W   = 8;
	localparam int CONF_W   = 2;
	localparam int KIND_W   = 3;
	localparam int ARCH_W   = 2;
	localparam int PAT_W    = 64;
	localparam int PLEN_W   = 4;
	localparam int SYS_W    = 10;
	localparam int IMM_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 64;
	localparam int PAT_BYTES = PAT_W / CODE_W;

	// Signature kinds
	localparam logic [KIND_W-1:0] KIND_ANCHORED = 3'd0;
	localparam logic [KIND_W-1:0] KIND_EPILOGUE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BODY     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CONST    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SYSCALL  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_STRREF   = 3'd5;

	// Architectures
	localparam logic [ARCH_W-1:0] ARCH_ANY     = 2'd0;
	localparam logic [ARCH_W-1:0] ARCH_X86_64  = 2'd1;
	localparam logic [ARCH_W-1:0] ARCH_AARCH64 = 2'd2;

	// Confidence codes
	localparam logic [CONF_W-1:0] CONF_LOW    = 2'd0;
	localparam logic [CONF_W-1:0] CONF_MEDIUM = 2'd1;
	localparam logic [CONF_W-1:0] CONF_HIGH   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIG_KIND   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIG_ARCH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_ARCH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_BYTES  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_MASK   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SYS = 3'd6;

	// Opcode bytes of interest
	localparam logic [CODE_W-1:0] OP_0F   = 8'h0F;
	localparam logic [CODE_W-1:0] OP_05   = 8'h05;
	localparam logic [CODE_W-1:0] OP_B8   = 8'hB8;
	localparam logic [CODE_W-1:0] OP_REXW = 8'h48;
	localparam logic [CODE_W-1:0] OP_C7   = 8'hC7;
	localparam logic [CODE_W-1:0] OP_C0   = 8'hC0;

	// Syscall site needs this many bytes from the start of 0F 05
	localparam int SITE_MIN = 7;
	localparam int COUNT_MIN_SAT = 32;

endpackage

/* rtl/core/masked_signature_scanner_core.sv */
// Top level of the masked signature scanner: byte stream in, one verdict per function out.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  byte     | byte_valid / byte_stall  | code_byte[7:0], last_byte
//  result   | result_valid/result_stall| matched, confidence[1:0]
//  config   | cfg_valid / cfg_ready    | cfg_index[2:0], cfg_data[63:0]
//
//  One byte per cycle sustained while byte_stall is low. A byte is registered in
//  the _s1 input register, then the history shift, masked compares and syscall
//  lookback update the function state in one pass as it leaves _s1; the last
//  byte's verdict is loaded into the result register as that byte leaves _s1.
//  Reset (arst_n low) clears control state and loads the register defaults; the
//  byte history is not cleared, its reads are qualified by the byte count.
//  byte_stall rises only when a last byte waits in _s1 while the result register
//  is full and stalled; cfg_ready is always high.
module masked_signature_scanner_core #(
	parameter int MAX_PATTERN = msscan_pkg::MAX_PATTERN_DEF,
	parameter int LOOKBACK    = msscan_pkg::LOOKBACK_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// byte channel
	input  logic                              byte_valid,
	output logic                              byte_stall,
	input  logic [msscan_pkg::CODE_W-1:0]     code_byte,
	input  logic                              last_byte,
	// result channel
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              matched,
	output logic [msscan_pkg::CONF_W-1:0]     confidence,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [msscan_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [msscan_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import msscan_pkg::*;

	// History depth covers the deepest lookback read and the longest pattern
	localparam int HIST_DEPTH = (LOOKBACK + 8 > MAX_PATTERN) ? LOOKBACK + 8 : MAX_PATTERN;
	localparam int COUNT_SAT  = (LOOKBACK + 8 > COUNT_MIN_SAT) ? LOOKBACK + 8 : COUNT_MIN_SAT;
	localparam int CNT_W      = $clog2(COUNT_SAT + 1);
	localparam int LEN_W      = $clog2(MAX_PATTERN + 1);
	localparam int NCAND      = 2 * LOOKBACK;

	// ---------------- configuration registers ----------------
	logic [KIND_W-1:0] sig_kind_q;
	logic [ARCH_W-1:0] sig_arch_q;
	logic [ARCH_W-1:0] code_arch_q;
	logic [PAT_W-1:0]  pat_bytes_q;
	logic [PAT_W-1:0]  pat_mask_q;
	logic [PLEN_W-1:0] pat_len_q;
	logic [SYS_W-1:0]  target_sys_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_kind_q   <= KIND_ANCHORED;
			sig_arch_q   <= ARCH_ANY;
			code_arch_q  <= ARCH_X86_64;
			pat_bytes_q  <= '0;
			pat_mask_q   <= '0;
			pat_len_q    <= PLEN_W'(1);
			target_sys_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SIG_KIND:   sig_kind_q   <= cfg_data[KIND_W-1:0];
				REG_SIG_ARCH:   sig_arch_q   <= cfg_data[ARCH_W-1:0];
				REG_CODE_ARCH:  code_arch_q  <= cfg_data[ARCH_W-1:0];
				REG_PAT_BYTES:  pat_bytes_q  <= cfg_data[PAT_W-1:0];
				REG_PAT_MASK:   pat_mask_q   <= cfg_data[PAT_W-1:0];
				REG_PAT_LEN:    pat_len_q    <= cfg_data[PLEN_W-1:0];
				REG_TARGET_SYS: target_sys_q <= cfg_data[SYS_W-1:0];
				default: ; // indexes past the list are ignored
			endcase
		end
	end

	// ---------------- handshake / input register ----------------
	logic              valid_s1;
	logic              last_s1;
	logic [CODE_W-1:0] byte_s1;
	logic              out_valid_q;
	logic              matched_q;
	logic [CONF_W-1:0] conf_q;
	logic              out_free;
	logic              s1_adv;
	logic              s1_free;

	// result register free this cycle if empty or its transaction completes now
	assign out_free   = !out_valid_q || !result_stall;
	// only a last byte needs the result register
	assign s1_adv     = valid_s1 && (!last_s1 || out_free);
	assign s1_free    = !valid_s1 || s1_adv;
	assign byte_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && byte_valid) begin
			byte_s1 <= code_byte;
			last_s1 <= last_byte;
		end
	end

	// ---------------- byte history (shift line, newest first) ----------------
	logic [CODE_W-1:0] hist_q   [HIST_DEPTH-1];
	logic [CODE_W-1:0] hist_new [HIST_DEPTH];

	always_comb begin
		hist_new[0] = byte_s1;
		for (int i = 1; i < HIST_DEPTH; i++) begin
			hist_new[i] = hist_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int i = 0; i < HIST_DEPTH - 1; i++) begin
				hist_q[i] <= hist_new[i];
			end
		end
	end

	// ---------------- per-function state ----------------
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_new;
	logic             anchored_q;
	logic             window_q;
	logic             sys_found_q;
	logic [IMM_W-1:0] sys_value_q;

	assign cnt_new = (cnt_q == CNT_W'(COUNT_SAT)) ? cnt_q : cnt_q + CNT_W'(1);

	// effective pattern length, clamped to MAX_PATTERN
	logic [PLEN_W:0]  plen_wide;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] anchor_at;

	assign plen_wide = {1'b0, pat_len_q};
	assign len       = (plen_wide > (PLEN_W+1)'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
	                                                           : LEN_W'(plen_wide);
	assign anchor_at = (len == '0) ? LEN_W'(1) : len;

	// masked window compare, one result per possible length; pattern byte k
	// lines up with history entry len-1-k, bytes past the eighth are wildcards
	logic [MAX_PATTERN:0] match_len;
	logic                 win_match;

	always_comb begin
		match_len[0] = 1'b1;
		for (int l = 1; l <= MAX_PATTERN; l++) begin
			match_len[l] = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (k < PAT_BYTES) begin
					if ((hist_new[l-1-k] & pat_mask_q[8*k +: CODE_W]) !=
					    (pat_bytes_q[8*k +: CODE_W] & pat_mask_q[8*k +: CODE_W]))
						match_len[l] = 1'b0;
				end
			end
		end
	end

	assign win_match = match_len[len];

	logic anchored_nx;
	logic window_nx;

	assign anchored_nx = anchored_q || ((cnt_new == CNT_W'(anchor_at)) && win_match);
	assign window_nx   = window_q   || ((cnt_new >= CNT_W'(len)) && win_match);

	// syscall lookback: history[6..5] = 0F 05; candidate 2(d-1) is B8 imm32 at
	// distance d, candidate 2(d-1)+1 is 48 C7 C0 imm32; lowest set bit wins
	logic             site_ok;
	logic [NCAND-1:0] cand;
	logic [NCAND-1:0] cand_first;
	logic [IMM_W-1:0] cand_val [NCAND];
	logic [IMM_W-1:0] pick_val;
	logic             sys_hit;
	logic             sys_found_nx;
	logic [IMM_W-1:0] sys_value_nx;

	assign site_ok = !sys_found_q && (hist_new[SITE_MIN-1] == OP_0F)
	                 && (hist_new[SITE_MIN-2] == OP_05);

	always_comb begin
		for (int d = 1; d <= LOOKBACK; d++) begin
			// d must not reach past the first byte of the function
			cand[2*(d-1)] = (cnt_new >= CNT_W'(SITE_MIN + d)) && (hist_new[6+d] == OP_B8);
			cand[2*(d-1)+1] = (cnt_new >= CNT_W'(SITE_MIN + 1 + d))
			                  && (hist_new[7+d] == OP_REXW)
			                  && (hist_new[6+d] == OP_C7)
			                  && (hist_new[5+d] == OP_C0);
			cand_val[2*(d-1)]   = {hist_new[2+d], hist_new[3+d], hist_new[4+d], hist_new[5+d]};
			cand_val[2*(d-1)+1] = {hist_new[1+d], hist_new[2+d], hist_new[3+d], hist_new[4+d]};
		end
	end

	assign cand_first = cand & (~cand + NCAND'(1));

	always_comb begin
		pick_val = '0;
		for (int c = 0; c < NCAND; c++) begin
			pick_val = pick_val | ({IMM_W{cand_first[c]}} & cand_val[c]);
		end
	end

	assign sys_hit      = site_ok && (cand != '0);
	assign sys_found_nx = sys_found_q || sys_hit;
	assign sys_value_nx = sys_hit ? pick_val : sys_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			anchored_q  <= 1'b0;
			window_q    <= 1'b0;
			sys_found_q <= 1'b0;
			sys_value_q <= '0;
		end else if (s1_adv) begin
			if (last_s1) begin
				// function closed: start afresh for the next one
				cnt_q       <= '0;
				anchored_q  <= 1'b0;
				window_q    <= 1'b0;
				sys_found_q <= 1'b0;
				sys_value_q <= '0;
			end else begin
				cnt_q       <= cnt_new;
				anchored_q  <= anchored_nx;
				window_q    <= window_nx;
				sys_found_q <= sys_found_nx;
				sys_value_q <= sys_value_nx;
			end
		end
	end

	// ---------------- verdict ----------------
	logic              arch_ok;
	logic              verdict;
	logic [CONF_W-1:0] verdict_conf;

	assign arch_ok = (sig_arch_q == ARCH_ANY) || (sig_arch_q == code_arch_q);

	always_comb begin
		verdict      = 1'b0;
		verdict_conf = CONF_LOW;
		if (arch_ok) begin
			unique case (sig_kind_q) inside
				KIND_ANCHORED: verdict = anchored_nx || (len == '0);
				KIND_EPILOGUE, KIND_BODY: verdict = window_nx;
				KIND_CONST: begin
					verdict      = window_nx;
					verdict_conf = window_nx ? CONF_MEDIUM : CONF_LOW;
				end
				KIND_SYSCALL: begin
					verdict = (code_arch_q == ARCH_X86_64) && sys_found_nx
					          && (sys_value_nx == IMM_W'(target_sys_q));
					verdict_conf = verdict ? CONF_HIGH : CONF_LOW;
				end
				default: ; // string reference and unused kinds never match
			endcase
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			matched_q <= verdict;
			conf_q    <= verdict_conf;
		end
	end

	assign result_valid = out_valid_q;
	assign matched      = matched_q;
	assign confidence   = conf_q;

endmodule

/* rtl/core/msscan_checker.sv */
// Port-level checks for the masked signature scanner, bound to the top level.
module msscan_props (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          byte_valid,
	input logic                          byte_stall,
	input logic                          last_byte,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic                          matched,
	input logic [msscan_pkg::CONF_W-1:0] confidence
);
	import msscan_pkg::*;

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(matched)
		&& $stable(confidence))
		else $error("stalled result changed");

	// no confidence without a match
	a_conf_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !matched |-> confidence == CONF_LOW)
		else $error("confidence set on a miss");

	// the byte side only backs up behind a full result register
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !byte_stall)
		else $error("byte channel stalled with empty result register");

	// a fresh result follows an accepted last byte
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(byte_valid && !byte_stall && last_byte, 2))
		else $error("result without a last byte");

endmodule

bind masked_signature_scanner_core msscan_props u_msscan_checker (.*);
